/* sv/psd_pkg.sv */
`timescale 1ns / 1ps

package psd_pkg;

   localparam int COORD_BITS      = 16;
   localparam int COORD_FRAC_BITS = 4;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int OUT_FRAC        = 8;
   localparam int OUT_WIDTH       = 21;

   // Derived widths.
   localparam int DIFF_W    = COORD_BITS + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int DOT_W     = PROD_W + 1;
   localparam int REM_W     = DOT_W + 1;
   localparam int T_W       = PARAM_FRAC_BITS + 1;
   localparam int RESID_W   = DIFF_W + T_W + 1;
   localparam int RES_SHIFT = PARAM_FRAC_BITS + COORD_FRAC_BITS - OUT_FRAC;
   localparam int RX_W      = RESID_W - RES_SHIFT;
   localparam int SQ_W      = 2 * RX_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int ROOT_W    = (SUM_W + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int CMP_W     = (ROOT_W > OUT_WIDTH) ? ROOT_W : OUT_WIDTH;

   // Stage counts of the pipeline sections.
   localparam int FRONT_LAT = 3;
   localparam int RESID_LAT = 4;
   localparam int PIPE_LAT  = FRONT_LAT + PARAM_FRAC_BITS + RESID_LAT + ROOT_W + 1;

   typedef enum logic [1:0] {
      T_ZERO = 2'd0,
      T_ONE  = 2'd1,
      T_DIV  = 2'd2
   } t_mode_type;

   typedef struct packed {
      logic                     valid;
      t_mode_type               mode;
      logic signed [DOT_W-1:0]  num;
      logic [DOT_W-1:0]         den;
      logic signed [DIFF_W-1:0] wx;
      logic signed [DIFF_W-1:0] wy;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } front_out_type;

   typedef struct packed {
      logic                     valid;
      logic [T_W-1:0]           t;
      logic signed [DIFF_W-1:0] wx;
      logic signed [DIFF_W-1:0] wy;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } param_out_type;

   typedef struct packed {
      logic             valid;
      logic [RAD_W-1:0] radicand;
   } resid_out_type;

endpackage

/* sv/point_segment_distance_unit.sv */
// An item passes the front end, divider, residual stage, square root and output register.
// Throughput: one item per cycle; busy never rises, the pipeline always moves.
// The rate is set by the fully pipelined divider (one quotient bit per stage)
// and the square root (one root bit per stage); the receiver cannot stall.
// Reset is synchronous and active high; it clears all valid bits only.
`timescale 1ns / 1ps

module point_segment_distance_unit import psd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   output logic                         rsp_valid,
   output logic [OUT_WIDTH-1:0]         rsp_distance
);

   // The datapath has no back pressure, so an item is taken on every cycle
   // that start is high.
   front_out_type     front_out;
   param_out_type     param_out;
   resid_out_type     resid_out;
   logic              root_valid;
   logic [ROOT_W-1:0] root;
   logic              rsp_valid_ff;
   logic [OUT_WIDTH-1:0] rsp_distance_ff, rsp_distance_in;

   assign busy = 1'b0;

   // Front end: differences, the two dot products and the case of t.
   psd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .query_x     (req_query_x),
      .query_y     (req_query_y),
      .out         (front_out)
   );

   // The segment parameter t, clamped to [0, 1] in Q1.16.
   psd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .in    (front_out),
      .out   (param_out)
   );

   // Residual vector to the projection and its squared length.
   psd_residual u_residual (
      .clock (clock),
      .reset (reset),
      .in    (param_out),
      .out   (resid_out)
   );

   psd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in        (resid_out),
      .out_valid (root_valid),
      .out_root  (root)
   );

   // The root saturates to the width of the result field.
   always_comb begin
      if (CMP_W'(root) > CMP_W'({OUT_WIDTH{1'b1}})) begin
         rsp_distance_in = '1;
      end else begin
         rsp_distance_in = OUT_WIDTH'(root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= root_valid;
      end
      rsp_distance_ff <= rsp_distance_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // Every accepted item gives its result on rsp_valid.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without an accepted item.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##PIPE_LAT !rsp_valid)
      else $error("result without an accepted item");

   // A query on the first endpoint is at distance zero.
   a_on_endpoint: assert property (@(posedge clock) disable iff (reset)
      (start && req_query_x == req_seg_start_x && req_query_y == req_seg_start_y)
      |-> ##PIPE_LAT (rsp_distance == '0))
      else $error("nonzero distance for query on first endpoint");

endmodule

/* sv/psd_front.sv */
`timescale 1ns / 1ps

module psd_front import psd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] seg_start_x,
   input  logic signed [COORD_BITS-1:0] seg_start_y,
   input  logic signed [COORD_BITS-1:0] seg_end_x,
   input  logic signed [COORD_BITS-1:0] seg_end_y,
   input  logic signed [COORD_BITS-1:0] query_x,
   input  logic signed [COORD_BITS-1:0] query_y,
   output front_out_type                out
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff, wx1_ff, wy1_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff, wx2_ff, wy2_ff;
   logic signed [PROD_W-1:0] pwx_ff, pwy_ff, pdx_ff, pdy_ff;
   front_out_type            out_ff, out_in;

   // Differences, products, then the two dot products and the case of t.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      dx1_ff <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
      dy1_ff <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
      wx1_ff <= DIFF_W'(query_x) - DIFF_W'(seg_start_x);
      wy1_ff <= DIFF_W'(query_y) - DIFF_W'(seg_start_y);
      pwx_ff <= wx1_ff * dx1_ff;
      pwy_ff <= wy1_ff * dy1_ff;
      pdx_ff <= dx1_ff * dx1_ff;
      pdy_ff <= dy1_ff * dy1_ff;
      dx2_ff <= dx1_ff;
      dy2_ff <= dy1_ff;
      wx2_ff <= wx1_ff;
      wy2_ff <= wy1_ff;
      out_ff <= out_in;
   end

   always_comb begin
      logic signed [DOT_W-1:0] num;
      logic signed [DOT_W-1:0] den;
      num = DOT_W'(pwx_ff) + DOT_W'(pwy_ff);
      den = DOT_W'(pdx_ff) + DOT_W'(pdy_ff);
      out_in.valid = v2_ff;
      out_in.num   = num;
      out_in.den   = den;
      out_in.wx    = wx2_ff;
      out_in.wy    = wy2_ff;
      out_in.dx    = dx2_ff;
      out_in.dy    = dy2_ff;
      priority if (den == '0 || num <= 0) begin
         out_in.mode = T_ZERO;
      end else if (num >= den) begin
         out_in.mode = T_ONE;
      end else begin
         out_in.mode = T_DIV;
      end
   end

   always_comb begin
      out       = out_ff;
      out.valid = v3_ff;
   end

endmodule

/* sv/psd_divider.sv */
`timescale 1ns / 1ps

module psd_divider import psd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  front_out_type in,
   output param_out_type out
);

   typedef struct packed {
      t_mode_type                   mode;
      logic [REM_W-1:0]             rem;
      logic [PARAM_FRAC_BITS-1:0]   q;
      logic [DOT_W-1:0]             den;
      logic signed [DIFF_W-1:0]     wx;
      logic signed [DIFF_W-1:0]     wy;
      logic signed [DIFF_W-1:0]     dx;
      logic signed [DIFF_W-1:0]     dy;
   } div_stage_type;

   logic          valid_ff [PARAM_FRAC_BITS];
   div_stage_type stage_ff [PARAM_FRAC_BITS];
   div_stage_type head;

   // Restoring division, one quotient bit per stage, most significant first.
   always_comb begin
      head.mode = in.mode;
      head.rem  = (in.mode == T_DIV) ? REM_W'(unsigned'(in.num)) : '0;
      head.q    = '0;
      head.den  = in.den;
      head.wx   = in.wx;
      head.wy   = in.wy;
      head.dx   = in.dx;
      head.dy   = in.dy;
   end

   for (genvar k = 0; k < PARAM_FRAC_BITS; k++) begin : g_stage
      div_stage_type src, stage_in;
      logic          src_valid;
      if (k == 0) begin : g_first
         assign src       = head;
         assign src_valid = in.valid;
      end else begin : g_next
         assign src       = stage_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      always_comb begin
         logic [REM_W-1:0] sh;
         sh       = {src.rem[REM_W-2:0], 1'b0};
         stage_in = src;
         if (sh >= {1'b0, src.den}) begin
            stage_in.rem = sh - {1'b0, src.den};
            stage_in.q   = {src.q[PARAM_FRAC_BITS-2:0], 1'b1};
         end else begin
            stage_in.rem = sh;
            stage_in.q   = {src.q[PARAM_FRAC_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         stage_ff[k] <= stage_in;
      end
   end

   always_comb begin
      div_stage_type last;
      last      = stage_ff[PARAM_FRAC_BITS-1];
      out.valid = valid_ff[PARAM_FRAC_BITS-1];
      out.wx    = last.wx;
      out.wy    = last.wy;
      out.dx    = last.dx;
      out.dy    = last.dy;
      unique case (last.mode)
         T_ONE:   out.t = T_W'(1) << PARAM_FRAC_BITS;
         T_DIV:   out.t = {1'b0, last.q};
         default: out.t = '0;
      endcase
   end

endmodule

/* sv/psd_residual.sv */
`timescale 1ns / 1ps

module psd_residual import psd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  param_out_type in,
   output resid_out_type out
);

   logic                      va_ff, vb_ff, vc_ff, vd_ff;
   logic signed [RESID_W-1:0] tx_ff, ty_ff;
   logic signed [DIFF_W-1:0]  wx_ff, wy_ff;
   logic [RX_W-1:0]           ax_ff, ay_ff, ax_in, ay_in;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff;
   logic [RAD_W-1:0]          sum_ff;

   // Residual per axis: w * 2^P - t * d, floored to Q.8, then its magnitude.
   always_comb begin
      logic signed [RESID_W-1:0] rx, ry;
      logic signed [RX_W-1:0]    sx, sy;
      rx    = (RESID_W'(wx_ff) <<< PARAM_FRAC_BITS) - tx_ff;
      ry    = (RESID_W'(wy_ff) <<< PARAM_FRAC_BITS) - ty_ff;
      sx    = RX_W'(rx >>> RES_SHIFT);
      sy    = RX_W'(ry >>> RES_SHIFT);
      ax_in = sx[RX_W-1] ? RX_W'(0) - unsigned'(sx) : unsigned'(sx);
      ay_in = sy[RX_W-1] ? RX_W'(0) - unsigned'(sy) : unsigned'(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= in.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      tx_ff  <= RESID_W'(signed'({1'b0, in.t}) * in.dx);
      ty_ff  <= RESID_W'(signed'({1'b0, in.t}) * in.dy);
      wx_ff  <= in.wx;
      wy_ff  <= in.wy;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      sqx_ff <= ax_ff * ax_ff;
      sqy_ff <= ay_ff * ay_ff;
      sum_ff <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
   end

   assign out.valid    = vd_ff;
   assign out.radicand = sum_ff;

endmodule

/* sv/psd_isqrt.sv */
`timescale 1ns / 1ps

module psd_isqrt import psd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  resid_out_type     in,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root
);

   localparam int REMQ_W = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [REMQ_W-1:0] rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];

   // Digit-by-digit square root, one root bit per stage.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              src_valid;
      logic [RAD_W-1:0]  src_rad;
      logic [REMQ_W-1:0] src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [REMQ_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;
      if (k == 0) begin : g_first
         assign src_valid = in.valid;
         assign src_rad   = in.radicand;
         assign src_rem   = '0;
         assign src_root  = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
      end

      always_comb begin
         logic [REMQ_W-1:0] r2, trial;
         r2    = {src_rem[REMQ_W-3:0], src_rad[RAD_W-1 -: 2]};
         trial = {src_root, 2'b01};
         if (r2 >= trial) begin
            rem_in  = r2 - trial;
            root_in = {src_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = r2;
            root_in = {src_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         rad_ff[k]  <= {src_rad[RAD_W-3:0], 2'b00};
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Scoreboard of expected distances. Each accepted item pushes the distance the
// block should report; each strobed result is checked against the oldest one.
class distance_scoreboard;
   logic [psd_pkg::OUT_WIDTH-1:0] pending_distances[$];
   int mismatch_count;
   int report_count;

   function new();
      mismatch_count = 0;
      report_count = 0;
   endfunction

   // Computes the floored distance from q to the segment p1-p2.
   function automatic logic [psd_pkg::OUT_WIDTH-1:0] segment_distance(
         input logic signed [15:0] x1, input logic signed [15:0] y1,
         input logic signed [15:0] x2, input logic signed [15:0] y2,
         input logic signed [15:0] qx, input logic signed [15:0] qy);
      longint dx, dy, wx, wy, num, den, t, one, rx, ry, mag;
      longint unsigned sum, root, bit_val;
      int shift;
      shift = psd_pkg::PARAM_FRAC_BITS + psd_pkg::COORD_FRAC_BITS - psd_pkg::OUT_FRAC;
      one = longint'(1) << psd_pkg::PARAM_FRAC_BITS;
      dx = longint'(x2) - longint'(x1);
      dy = longint'(y2) - longint'(y1);
      wx = longint'(qx) - longint'(x1);
      wy = longint'(qy) - longint'(y1);
      num = wx * dx + wy * dy;
      den = dx * dx + dy * dy;
      if (den == 0 || num <= 0) begin
         t = 0;
      end else if (num >= den) begin
         t = one;
      end else begin
         t = (num << psd_pkg::PARAM_FRAC_BITS) / den;
      end
      // Arithmetic shift floors toward minus infinity.
      rx = (wx * one - t * dx) >>> shift;
      ry = (wy * one - t * dy) >>> shift;
      sum = longint'(rx * rx) + longint'(ry * ry);
      root = 0;
      bit_val = longint'(1) << 62;
      while (bit_val > sum) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (sum >= root + bit_val) begin
            sum = sum - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      mag = (longint'(1) << psd_pkg::OUT_WIDTH) - 1;
      if (root > mag) root = mag;
      return root[psd_pkg::OUT_WIDTH-1:0];
   endfunction

   function void note_item(input logic signed [15:0] x1, input logic signed [15:0] y1,
         input logic signed [15:0] x2, input logic signed [15:0] y2,
         input logic signed [15:0] qx, input logic signed [15:0] qy);
      pending_distances.insert(pending_distances.size(),
                               segment_distance(x1, y1, x2, y2, qx, qy));
   endfunction

   function void check_distance(input logic [psd_pkg::OUT_WIDTH-1:0] actual);
      logic [psd_pkg::OUT_WIDTH-1:0] expected;
      if (pending_distances.size() == 0) begin
         mismatch_count++;
         if (report_count < 10) begin
            report_count++;
            $display("unexpected result: distance %0d", actual);
         end
         return;
      end
      expected = pending_distances.pop_front();
      if (expected !== actual) begin
         mismatch_count++;
         if (report_count < 10) begin
            report_count++;
            $display("distance differs: expected %0d, actual %0d", expected, actual);
         end
      end
   endfunction
endclass

module testbench;
   import psd_pkg::*;

   // The watchdog limit covers the pipeline depth and the longest random
   // sender gap many times over.
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_BITS-1:0] req_seg_start_x = '0;
   logic signed [COORD_BITS-1:0] req_seg_start_y = '0;
   logic signed [COORD_BITS-1:0] req_seg_end_x = '0;
   logic signed [COORD_BITS-1:0] req_seg_end_y = '0;
   logic signed [COORD_BITS-1:0] req_query_x = '0;
   logic signed [COORD_BITS-1:0] req_query_y = '0;
   logic rsp_valid;
   logic [OUT_WIDTH-1:0] rsp_distance;

   distance_scoreboard board = new();
   int idle_cycles = 0;
   int sender_idle_percent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   point_segment_distance_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_seg_start_x(req_seg_start_x),
      .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x(req_seg_end_x),
      .req_seg_end_y(req_seg_end_y),
      .req_query_x(req_query_x),
      .req_query_y(req_query_y),
      .rsp_valid(rsp_valid),
      .rsp_distance(rsp_distance)
   );

   // Results are sampled at the rising edge; the strobe lasts one cycle, so
   // every edge with rsp_valid high carries exactly one result.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_distance(rsp_distance);
      end
   end

   // The watchdog counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("point_segment_distance_unit: mismatch");
            $finish;
         end
      end
   end

   // Presents one item from the falling edge and holds it until accepted.
   // The sender inserts random idle cycles first, by the current phase rate.
   task automatic send_item(input logic [15:0] x1, input logic [15:0] y1,
         input logic [15:0] x2, input logic [15:0] y2,
         input logic [15:0] qx, input logic [15:0] qy);
      while ($urandom_range(99) < sender_idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_seg_start_x <= x1;
      req_seg_start_y <= y1;
      req_seg_end_x <= x2;
      req_seg_end_y <= y2;
      req_query_x <= qx;
      req_query_y <= qy;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(x1, y1, x2, y2, qx, qy);
      @(negedge clock);
   endtask

   // Random coordinate: values near the base as often as full-range values, with
   // a share of the extremes so every bit toggles.
   function automatic logic [15:0] random_coord(input logic [15:0] base);
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return base + 16'($urandom_range(0, 511)) - 16'd256;
      else if (pick < 8) return 16'($urandom);
      else if (pick == 8) return 16'h7fff;
      else return 16'h8000;
   endfunction

   task automatic send_random_item();
      logic [15:0] x1, y1, x2, y2;
      x1 = 16'($urandom);
      y1 = 16'($urandom);
      x2 = random_coord(x1);
      y2 = random_coord(y1);
      // A share of zero-length segments.
      if ($urandom_range(19) == 0) begin
         x2 = x1;
         y2 = y1;
      end
      send_item(x1, y1, x2, y2, random_coord(x1), random_coord(y1));
   endtask

   initial begin
      int phase;
      int wait_cycles;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items: extremes, zero-length segments, queries beyond
      // either end and projections inside the segment.
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(16'h0010, 16'h0020, 16'h0010, 16'h0020, 16'h0050, 16'h0060);
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
      send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
      send_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      send_item(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'hff00, 16'h0040);
      send_item(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0200, 16'hffc0);
      send_item(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0080, 16'h0040);
      send_item(16'h0000, 16'h0000, 16'h0030, 16'h0070, 16'h0011, 16'hfff3);
      send_item(16'h0000, 16'h0000, 16'h0003, 16'h0007, 16'h0001, 16'h0005);
      send_item(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000);
      send_item(16'h0000, 16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000);
      send_item(16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h7fff, 16'h7fff);
      send_item(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 16'hffff);

      // Random items in four phases of sender idling; the receiver cannot
      // stall, so only the sender's gaps change between phases.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: sender_idle_percent = 0;
            1: sender_idle_percent = 61;
            2: sender_idle_percent = 0;
            default: sender_idle_percent = 29;
         endcase
         repeat (250) send_random_item();
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (board.pending_distances.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_distances.size() == 0) begin
         $display("point_segment_distance_unit: match");
      end else begin
         $display("point_segment_distance_unit: mismatch");
      end
      $finish;
   end
endmodule
